>>> rtl/ius_pkg.sv
`default_nettype none

package ius_pkg;

    // Field widths of the ports
    localparam int PIX_W      = 8;
    localparam int VAL_W      = 10;
    localparam int ROW_W      = 13;
    localparam int COL_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;

    // Source block coordinates carried to the back end
    localparam int BROW_W = ROW_W - 1;
    localparam int BCOL_W = COL_W - 1;

    localparam int HEIGHT_LIMIT  = 4096;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int QUEUE_DEPTH   = 4;
    localparam int NUM_BLK       = 4;

    // Bit positions of the block mask, in emission order
    localparam int BLK_UL = 0;  // (i-1, j-1)
    localparam int BLK_UP = 1;  // (i-1, j)
    localparam int BLK_LF = 2;  // (i,   j-1)
    localparam int BLK_HR = 3;  // (i,   j)

    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [PIX_W-1:0]   up;
        logic [PIX_W-1:0]   lf;
        logic [PIX_W-1:0]   ul;
        logic [BROW_W-1:0]  row;
        logic [BCOL_W-1:0]  col;
        logic [NUM_BLK-1:0] blk_mask;
        logic               frame_end;
    } ius_desc_t;

endpackage

`default_nettype wire

>>> rtl/ius_front.sv
`default_nettype none

module ius_front import ius_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PIX_W-1:0]      pixel,
    input  wire logic                  cfg_wr,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output ius_desc_t                  push_desc
);

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WC_W = (CW + 1 > FW_W) ? CW + 1 : FW_W;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    logic              mode_reg;
    logic [FW_W-1:0]   width_reg;
    logic [FH_W-1:0]   height_reg;
    logic [BROW_W-1:0] row_reg;
    logic [CW-1:0]     col_reg;

    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [BROW_W-1:0] s1_row_reg;
    logic [CW-1:0]     s1_col_reg;
    logic              s1_last_col_reg;
    logic              s1_last_row_reg;
    logic [PIX_W-1:0]  up_reg;
    logic [PIX_W-1:0]  lf_reg;
    logic [PIX_W-1:0]  ul_reg;

    logic [PIX_W-1:0]  line_mem [MAX_WIDTH];

    logic [WC_W-1:0]    width_ext;
    logic [WC_W-1:0]    width_eff;
    logic [CW-1:0]      width_m1;
    logic [FH_W-1:0]    height_eff;
    logic [BROW_W-1:0]  height_m1;
    logic               last_col;
    logic               last_row;
    logic               accept;
    logic               cfg_hit;
    logic [NUM_BLK-1:0] blk_mask;
    logic               s1_advance;

    // Clamp the frame size to the supported range
    always_comb
    begin
        width_ext = WC_W'(width_reg);
        if (width_ext < WC_W'(2))
        begin
            width_eff = WC_W'(2);
        end
        else if (width_ext > WC_W'(MAX_WIDTH))
        begin
            width_eff = WC_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        width_m1 = CW'(width_eff - WC_W'(1));

        if (height_reg < FH_W'(2))
        begin
            height_eff = FH_W'(2);
        end
        else if (height_reg > FH_W'(HEIGHT_LIMIT))
        begin
            height_eff = FH_W'(HEIGHT_LIMIT);
        end
        else
        begin
            height_eff = height_reg;
        end
        height_m1 = BROW_W'(height_eff - FH_W'(1));
    end

    assign last_col = (col_reg == width_m1);
    assign last_row = (row_reg == height_m1);
    assign cfg_hit  = cfg_wr && ((cfg_index == REG_MODE) || (cfg_index == REG_WIDTH)
                                 || (cfg_index == REG_HEIGHT));

    // Classify: which of the four candidate blocks this pixel completes
    always_comb
    begin
        blk_mask = '0;
        if (!mode_reg)
        begin
            blk_mask[BLK_HR] = 1'b1;
        end
        else
        begin
            blk_mask[BLK_UL] = (s1_row_reg != '0) && (s1_col_reg != '0);
            blk_mask[BLK_UP] = (s1_row_reg != '0) && s1_last_col_reg;
            blk_mask[BLK_LF] = s1_last_row_reg && (s1_col_reg != '0);
            blk_mask[BLK_HR] = s1_last_row_reg && s1_last_col_reg;
        end
    end

    assign push_valid = s1_valid_reg && (blk_mask != '0);
    assign s1_advance = s1_valid_reg && (push_ready || (blk_mask == '0));
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign accept     = in_valid && !in_stall;

    always_comb
    begin
        push_desc.pix       = s1_pix_reg;
        push_desc.up        = up_reg;
        push_desc.lf        = lf_reg;
        push_desc.ul        = ul_reg;
        push_desc.row       = s1_row_reg;
        push_desc.col       = BCOL_W'(s1_col_reg);
        push_desc.blk_mask  = blk_mask;
        push_desc.frame_end = s1_last_row_reg && s1_last_col_reg;
    end

    // Line store: read the old row entry while overwriting it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_reg] <= pixel;
            up_reg            <= line_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= pixel;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            width_reg    <= FW_W'(3);
            height_reg   <= FH_W'(3);
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            lf_reg       <= '0;
            ul_reg       <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                    default:    ;
                endcase
            end

            // Restart the frame on any register write
            if (cfg_hit)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + BROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (cfg_hit)
            begin
                lf_reg <= '0;
                ul_reg <= '0;
            end
            else if (s1_advance)
            begin
                lf_reg <= s1_pix_reg;
                if (mode_reg)
                begin
                    ul_reg <= up_reg;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/ius_queue.sv
`default_nettype none

module ius_queue import ius_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire ius_desc_t push_desc,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output ius_desc_t      pop_desc
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    ius_desc_t        slot_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = slot_mem[head_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[tail_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                tail_reg <= tail_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                head_reg <= head_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/ius_back.sv
`default_nettype none

module ius_back import ius_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      pop_valid,
    output logic           pop_ready,
    input  wire ius_desc_t pop_desc,
    output logic           out_valid,
    input  wire logic      out_stall,
    output logic [VAL_W-1:0] value,
    output logic [ROW_W-1:0] out_row,
    output logic [COL_W-1:0] out_col,
    output logic           last,
    output logic           frame_end
);

    typedef enum logic [1:0] {
        Q_TL,
        Q_TR,
        Q_BL,
        Q_BR
    } quad_t;

    quad_t              quad_reg;
    quad_t              quad_next;
    logic [NUM_BLK-1:0] done_reg;
    logic               out_valid_reg;
    logic [VAL_W-1:0]   value_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic               last_reg;
    logic               frame_end_reg;

    logic [NUM_BLK-1:0] cur_mask;
    logic [NUM_BLK-1:0] sel_oh;
    logic               last_blk;
    logic [PIX_W-1:0]   pa;
    logic [PIX_W-1:0]   pb;
    logic [PIX_W-1:0]   pc;
    logic [PIX_W-1:0]   pd;
    logic [BROW_W-1:0]  brow;
    logic [BCOL_W-1:0]  bcol;
    logic [VAL_W-1:0]   val;
    logic               res_last;
    logic               load;

    // Pick the lowest pending block of the head item
    assign cur_mask = pop_desc.blk_mask & ~done_reg;
    assign sel_oh   = cur_mask & (~cur_mask + NUM_BLK'(1));
    assign last_blk = ((cur_mask & ~sel_oh) == '0);

    always_comb
    begin
        priority if (sel_oh[BLK_UL])
        begin
            pa   = pop_desc.ul;
            pb   = pop_desc.up;
            pc   = pop_desc.lf;
            pd   = pop_desc.pix;
            brow = pop_desc.row - BROW_W'(1);
            bcol = pop_desc.col - BCOL_W'(1);
        end
        else if (sel_oh[BLK_UP])
        begin
            pa   = pop_desc.up;
            pb   = pop_desc.up;
            pc   = pop_desc.pix;
            pd   = pop_desc.pix;
            brow = pop_desc.row - BROW_W'(1);
            bcol = pop_desc.col;
        end
        else if (sel_oh[BLK_LF])
        begin
            pa   = pop_desc.lf;
            pb   = pop_desc.pix;
            pc   = pop_desc.lf;
            pd   = pop_desc.pix;
            brow = pop_desc.row;
            bcol = pop_desc.col - BCOL_W'(1);
        end
        else
        begin
            pa   = pop_desc.pix;
            pb   = pop_desc.pix;
            pc   = pop_desc.pix;
            pd   = pop_desc.pix;
            brow = pop_desc.row;
            bcol = pop_desc.col;
        end
    end

    always_comb
    begin
        unique case (quad_reg)
            Q_TL:
            begin
                val       = {pa, 2'b00};
                quad_next = Q_TR;
            end
            Q_TR:
            begin
                val       = {(VAL_W-1)'(pa) + (VAL_W-1)'(pb), 1'b0};
                quad_next = Q_BL;
            end
            Q_BL:
            begin
                val       = {(VAL_W-1)'(pa) + (VAL_W-1)'(pc), 1'b0};
                quad_next = Q_BR;
            end
            Q_BR:
            begin
                val       = VAL_W'(pa) + VAL_W'(pb) + VAL_W'(pc) + VAL_W'(pd);
                quad_next = Q_TL;
            end
            default:
            begin
                val       = '0;
                quad_next = Q_TL;
            end
        endcase
    end

    assign res_last  = (quad_reg == Q_BR) && last_blk;
    assign load      = pop_valid && (!out_valid_reg || !out_stall);
    assign pop_ready = load && res_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_reg      <= Q_TL;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            last_reg      <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                value_reg     <= val;
                row_reg       <= {brow, quad_reg[1]};
                col_reg       <= {bcol, quad_reg[0]};
                last_reg      <= res_last;
                frame_end_reg <= res_last && pop_desc.frame_end;
                quad_reg      <= quad_next;
                if (quad_reg == Q_BR)
                begin
                    done_reg <= last_blk ? '0 : (done_reg | sel_oh);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign last      = last_reg;
    assign frame_end = frame_end_reg;

endmodule

`default_nettype wire

>>> rtl/image_upscale_2x_core.sv
`default_nettype none

// 2x image upscaler. Feed source pixels in row-major order, frame_width per
// row and frame_height rows per frame; each source pixel owns a 2x2 output
// block that comes out as four items (top-left, top-right, bottom-left,
// bottom-right) in quarter units with out_row/out_col in the upscaled image.
// Nearest mode emits a pixel's block right away. Bilinear mode emits a block
// once its right and lower neighbours have arrived, so the first row emits
// nothing and the last row and column flush the edge blocks, with edges
// replicated. "last" marks the final item caused by an input pixel, and
// "frame_end" the final item of the frame. Any register write restarts the
// frame; write registers only while the block is idle. Rate: the front end
// takes one pixel per cycle unless stalled, into a four-entry queue; the
// back end produces one output item per cycle unless out_stall holds it,
// four items for each block that a pixel completes (0, 1, 2 or 4 blocks).
// A pixel passes the line store read and the stage registers, then a queue
// slot, then the output register. The line store is one memory of
// MAX_WIDTH bytes with one write and one read per pixel; it needs no
// clearing, since rows after the first read only what the same frame
// wrote.

module image_upscale_2x_core import ius_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // pixel input
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PIX_W-1:0]      pixel,
    // result output
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [VAL_W-1:0]           value,
    output logic [ROW_W-1:0]           out_row,
    output logic [COL_W-1:0]           out_col,
    output logic                       last,
    output logic                       frame_end,
    // register writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ius_desc_t push_desc;
    ius_desc_t pop_desc;
    logic      push_valid;
    logic      push_ready;
    logic      pop_valid;
    logic      pop_ready;
    logic      cfg_wr;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Front: track position, read the line store, classify finished blocks
    ius_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .cfg_wr     (cfg_wr),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    // Hold pending items so front and back stall independently
    ius_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    // Back: expand each block into four weighted output items
    ius_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .out_row   (out_row),
        .out_col   (out_col),
        .last      (last),
        .frame_end (frame_end)
    );

endmodule

`default_nettype wire
